[src/pbe_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and SHA-256 constants for the PCR bank extend engine.
// No dependencies.
package pbe_pkg;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] alg_sel;
		logic [4:0]  reg_idx;
		logic [5:0]  dgst_len;
		logic [63:0] digest_word_0;
		logic [63:0] digest_word_1;
		logic [63:0] digest_word_2;
		logic [63:0] digest_word_3;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  value_size;
		logic [63:0] value_word_0;
		logic [63:0] value_word_1;
		logic [63:0] value_word_2;
		logic [63:0] value_word_3;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic       capture;
		logic       build;
		logic       round;
		logic [5:0] round_idx;
		logic       add_h;
		logic       load_b;
		logic       commit;
		logic       respond;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_hash;
		logic two_blocks;
	} sts_t;

	localparam logic [1:0] ACT_EXTEND = 2'd0;
	localparam logic [1:0] ACT_READ   = 2'd1;
	localparam logic [1:0] ACT_RESET  = 2'd2;
	localparam logic [1:0] ACT_NONE   = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_INDEX = 3'd1;
	localparam logic [2:0] ST_BAD_ALG   = 3'd2;
	localparam logic [2:0] ST_REFUSED   = 3'd3;
	localparam logic [2:0] ST_BAD_SIZE  = 3'd4;

	localparam logic [15:0] ALG_SHORT = 16'h0004;
	localparam logic [15:0] ALG_LONG  = 16'h000B;
	localparam logic [5:0]  SHORT_SIZE = 6'd20;
	localparam logic [5:0]  LONG_SIZE  = 6'd32;
	localparam logic [5:0]  MAX_DIGEST = 6'd32;
	localparam logic [4:0]  RESET_GUARD = 5'd16;
	localparam logic [6:0]  ONE_BLOCK_MAX = 7'd55;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

[src/pbe_datapath.sv]
`timescale 1ns / 1ps
// Datapath: request register, both PCR banks, SHA-256 round unit, response register.
// Depends on pbe_pkg.
module pbe_datapath #(
	parameter int REGISTER_COUNT = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  pbe_pkg::req_t req,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	input  pbe_pkg::cmd_t cmd,
	output pbe_pkg::sts_t sts,
	output logic          done,
	output pbe_pkg::rsp_t rsp
);
	import pbe_pkg::*;

	localparam int IW = $clog2(REGISTER_COUNT);

	req_t        req_q;
	logic        loc4_q;
	logic [159:0] sbank_q [REGISTER_COUNT];
	logic [255:0] lbank_q [REGISTER_COUNT];
	logic [31:0] blk2_q [16];
	logic [31:0] hv_q [8];
	logic [31:0] wv_q [8];
	logic [31:0] w_q [16];
	rsp_t        rsp_q;
	rsp_t        rsp_d;
	logic        done_q;

	logic [IW-1:0] idx;
	logic          idx_ok, is_short, is_long, size_ok;
	logic [2:0]    dec_status;
	logic [159:0]  sval;
	logic [255:0]  lval;
	logic [7:0]    old_b [32];
	logic [7:0]    dig_b [32];
	logic [255:0]  dig_cat;
	logic [6:0]    msg_len;
	logic [9:0]    msg_bits;
	logic [7:0]    nbuf [128];
	logic          two_blk;

	assign idx      = req_q.reg_idx[IW-1:0];
	assign idx_ok   = {1'b0, req_q.reg_idx} < 6'(REGISTER_COUNT);
	assign is_short = req_q.alg_sel == ALG_SHORT;
	assign is_long  = req_q.alg_sel == ALG_LONG;
	assign size_ok  = req_q.dgst_len <= MAX_DIGEST;
	assign sval     = sbank_q[idx];
	assign lval     = lbank_q[idx];
	assign dig_cat  = {req_q.digest_word_0, req_q.digest_word_1,
		req_q.digest_word_2, req_q.digest_word_3};
	assign msg_len  = 7'(is_long ? LONG_SIZE : SHORT_SIZE) + {1'b0, req_q.dgst_len};
	assign msg_bits = {msg_len, 3'b000};

	always_comb begin
		dec_status = ST_OK;
		if (req_q.action != ACT_NONE && !idx_ok) begin
			dec_status = ST_BAD_INDEX;
		end else if (req_q.action == ACT_EXTEND || req_q.action == ACT_READ) begin
			if (!is_short && !is_long)
				dec_status = ST_BAD_ALG;
			else if (req_q.action == ACT_EXTEND && !size_ok)
				dec_status = ST_BAD_SIZE;
		end else if (req_q.action == ACT_RESET) begin
			if (req_q.reg_idx < RESET_GUARD && !loc4_q)
				dec_status = ST_REFUSED;
		end
	end

	assign two_blk = msg_len > ONE_BLOCK_MAX;
	assign sts = '{need_hash: (req_q.action == ACT_EXTEND && dec_status == ST_OK),
		two_blocks: two_blk};

	// padded message: old value, digest bytes, 0x80, zeros, bit length at block end
	always_comb begin
		logic [7:0] mb;
		for (int j = 0; j < 32; j++) begin
			dig_b[j] = dig_cat[255-8*j -: 8];
			if (is_long)
				old_b[j] = lval[255-8*j -: 8];
			else if (j < 20)
				old_b[j] = sval[159-8*j -: 8];
			else
				old_b[j] = 8'h00;
		end
		for (int i = 0; i < 128; i++) begin
			mb = 8'h00;
			if (i < 32 && (is_long || i < 20))
				mb = old_b[5'(i)];
			else if (is_long && i >= 32 && i < 64)
				mb = dig_b[5'(i - 32)];
			else if (!is_long && i >= 20 && i < 52)
				mb = dig_b[5'(i - 20)];
			if (7'(i) < msg_len && i < 64)
				nbuf[i] = mb;
			else if (i < 65 && 7'(i) == msg_len)
				nbuf[i] = 8'h80;
			else
				nbuf[i] = 8'h00;
			if (two_blk) begin
				if (i == 126) nbuf[i] = {6'd0, msg_bits[9:8]};
				if (i == 127) nbuf[i] = msg_bits[7:0];
			end else begin
				if (i == 62) nbuf[i] = {6'd0, msg_bits[9:8]};
				if (i == 63) nbuf[i] = msg_bits[7:0];
			end
		end
	end

	// round logic
	logic [31:0] ra, rb, rc, rd, re, rf, rg, rh, t1, t2, w_new;
	assign ra = wv_q[0]; assign rb = wv_q[1]; assign rc = wv_q[2]; assign rd = wv_q[3];
	assign re = wv_q[4]; assign rf = wv_q[5]; assign rg = wv_q[6]; assign rh = wv_q[7];
	assign t1 = rh + (rotr(re, 6) ^ rotr(re, 11) ^ rotr(re, 25)) + ((re & rf) ^ (~re & rg))
		+ ROUND_K[cmd.round_idx] + w_q[0];
	assign t2 = (rotr(ra, 2) ^ rotr(ra, 13) ^ rotr(ra, 22)) + ((ra & rb) ^ (ra & rc) ^ (rb & rc));
	assign w_new = w_q[0] + (rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3)) + w_q[9]
		+ (rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10));

	// response: status always, register value only on a good read
	always_comb begin
		rsp_d = '0;
		if (cmd.respond) begin
			rsp_d.status = dec_status;
			if (req_q.action == ACT_READ && dec_status == ST_OK) begin
				if (is_long) begin
					rsp_d.value_size   = LONG_SIZE;
					rsp_d.value_word_0 = lval[255:192];
					rsp_d.value_word_1 = lval[191:128];
					rsp_d.value_word_2 = lval[127:64];
					rsp_d.value_word_3 = lval[63:0];
				end else begin
					rsp_d.value_size   = SHORT_SIZE;
					rsp_d.value_word_0 = sval[159:96];
					rsp_d.value_word_1 = sval[95:32];
					rsp_d.value_word_2 = {sval[31:0], 32'd0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			req_q <= req;
		if (cmd.build) begin
			for (int k = 0; k < 16; k++)
				blk2_q[k] <= {nbuf[64+4*k], nbuf[65+4*k], nbuf[66+4*k], nbuf[67+4*k]};
			for (int k = 0; k < 8; k++) begin
				hv_q[k] <= INIT_H[k];
				wv_q[k] <= INIT_H[k];
			end
			for (int k = 0; k < 16; k++)
				w_q[k] <= {nbuf[4*k], nbuf[4*k+1], nbuf[4*k+2], nbuf[4*k+3]};
		end else if (cmd.round) begin
			wv_q[0] <= t1 + t2;
			wv_q[1] <= ra; wv_q[2] <= rb; wv_q[3] <= rc;
			wv_q[4] <= rd + t1;
			wv_q[5] <= re; wv_q[6] <= rf; wv_q[7] <= rg;
			for (int k = 0; k < 15; k++) w_q[k] <= w_q[k+1];
			w_q[15] <= w_new;
		end else if (cmd.add_h) begin
			for (int k = 0; k < 8; k++) hv_q[k] <= hv_q[k] + wv_q[k];
		end else if (cmd.load_b) begin
			for (int k = 0; k < 8; k++) wv_q[k] <= hv_q[k];
			for (int k = 0; k < 16; k++)
				w_q[k] <= blk2_q[k];
		end
		if (cmd.respond || cmd.commit)
			rsp_q <= rsp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loc4_q <= 1'b0;
			done_q <= 1'b0;
			for (int r = 0; r < REGISTER_COUNT; r++) begin
				sbank_q[r] <= '0;
				lbank_q[r] <= '0;
			end
		end else begin
			if (cfg_we)
				loc4_q <= cfg_wdata;
			done_q <= cmd.respond | cmd.commit;
			if (cmd.respond && req_q.action == ACT_RESET && dec_status == ST_OK) begin
				sbank_q[idx] <= '0;
				lbank_q[idx] <= '0;
			end
			if (cmd.commit) begin
				if (is_long)
					lbank_q[idx] <= {hv_q[0], hv_q[1], hv_q[2], hv_q[3],
						hv_q[4], hv_q[5], hv_q[6], hv_q[7]};
				else
					sbank_q[idx] <= {hv_q[0], hv_q[1], hv_q[2], hv_q[3], hv_q[4]};
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

[src/pbe_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine: sequences decode, SHA-256 rounds, block chaining and commit.
// Depends on pbe_pkg.
module pbe_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pbe_pkg::sts_t sts,
	output pbe_pkg::cmd_t cmd
);
	import pbe_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_ROUND  = 6'b000100,
		S_ADDH   = 6'b001000,
		S_LOADB  = 6'b010000,
		S_COMMIT = 6'b100000
	} state_t;

	state_t     state_q, state_d;
	logic [5:0] round_q;
	logic       blk_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.round_idx = round_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.need_hash) begin
					cmd.build = 1'b1;
					state_d = S_ROUND;
				end else begin
					cmd.respond = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				if (round_q == 6'd63)
					state_d = S_ADDH;
			end
			S_ADDH: begin
				cmd.add_h = 1'b1;
				state_d = (sts.two_blocks && !blk_q) ? S_LOADB : S_COMMIT;
			end
			S_LOADB: begin
				cmd.load_b = 1'b1;
				state_d = S_ROUND;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			round_q <= '0;
			blk_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.round)
				round_q <= round_q + 6'd1;
			else
				round_q <= '0;
			if (cmd.build)
				blk_q <= 1'b0;
			else if (cmd.load_b)
				blk_q <= 1'b1;
		end
	end

	assign busy = state_q != S_IDLE;

endmodule

[src/pcr_bank_extend_engine_unit.sv]
`timescale 1ns / 1ps
// PCR bank extend engine: top level joining controller and datapath.
// Depends on pbe_pkg, pbe_ctrl, pbe_datapath.
//
// Usage: drive req and raise start; the request transfers at a clock edge where
// start is high and busy is low. Exactly one response per request appears on rsp
// for a single cycle with done high; the receiver has no way to stall it.
// cfg_we/cfg_wdata write locality4_enabled; write only while idle.
// Reads, resets, errors and action 3 answer straight from decode; an extend runs one
// compression for a message of up to 55 bytes and two for a longer one.
// One SHA-256 round per cycle in a single shared round unit sets the extend time.
// A new request may transfer in the same cycle done is shown.
// Reset clears both banks, locality 4 and the controller at once; no sweep.
module pcr_bank_extend_engine_unit #(
	parameter int REGISTER_COUNT = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pbe_pkg::req_t req,
	output logic          done,
	output pbe_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic          cfg_wdata
);
	import pbe_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pbe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	pbe_datapath #(
		.REGISTER_COUNT (REGISTER_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.done      (done),
		.rsp       (rsp)
	);

endmodule

[src/pbe_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the PCR bank extend engine, bound to the top level.
// Depends on pbe_pkg.
module pbe_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input pbe_pkg::rsp_t rsp
);
	import pbe_pkg::*;

	// a transfer always starts work
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("not busy after request transfer");

	// every request passes through capture and decode before its response, so responses never abut
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("back-to-back responses");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.status <= ST_BAD_SIZE) else $error("status code out of range");

	a_size_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.value_size == 6'd0 || (rsp.status == ST_OK &&
		(rsp.value_size == SHORT_SIZE || rsp.value_size == LONG_SIZE))))
		else $error("bad value size");

endmodule

bind pcr_bank_extend_engine_unit pbe_checker u_pbe_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

[test/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for pcr_bank_extend_engine_unit: directed and random requests,
// SHA-256 based prediction of both register banks. Depends on pbe_pkg and the RTL.
module tb;
	import pbe_pkg::*;

	localparam int REGS = 24;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	pcr_bank_extend_engine_unit #(.REGISTER_COUNT(REGS)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predicted register contents and locality setting
	logic [159:0] short_bank [REGS];
	logic [255:0] long_bank [REGS];
	logic loc4;
	rsp_t rsp_queue [$];
	int errors = 0;
	bit idle_on = 1'b1;

	localparam logic [31:0] K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void sha_block(ref logic [31:0] h [8], input logic [511:0] blk);
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
		for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
		for (int i = 16; i < 64; i++) begin
			s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		a = h[0]; b = h[1]; c = h[2]; d = h[3];
		e = h[4]; f = h[5]; g = h[6]; hh = h[7];
		for (int i = 0; i < 64; i++) begin
			t1 = hh + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + K[i] + w[i];
			t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			hh = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		h[0] += a; h[1] += b; h[2] += c; h[3] += d;
		h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
	endfunction

	// SHA-256 of msg bytes [0..len) where byte 0 sits in msg[1023:1016]
	function automatic logic [255:0] sha256_msg(input logic [1023:0] msg, input int len);
		logic [1023:0] buf_bits;
		logic [31:0] h [8];
		logic [255:0] dgst;
		int total;
		total = (len <= 55) ? 64 : 128;
		buf_bits = '0;
		for (int i = 0; i < len; i++) buf_bits[1023 - 8*i -: 8] = msg[1023 - 8*i -: 8];
		buf_bits[1023 - 8*len -: 8] = 8'h80;
		for (int i = 0; i < 8; i++)
			buf_bits[1023 - 8*(total - 1 - i) -: 8] = 8'(64'(len * 8) >> (8*i));
		h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		sha_block(h, buf_bits[1023:512]);
		if (total == 128) sha_block(h, buf_bits[511:0]);
		for (int i = 0; i < 8; i++) dgst[255 - 32*i -: 32] = h[i];
		return dgst;
	endfunction

	function automatic rsp_t predict_pcr_op(input req_t r);
		rsp_t o;
		logic [255:0] dig, hv;
		logic [1023:0] msg;
		int old;
		o = '0;
		dig = {r.digest_word_0, r.digest_word_1, r.digest_word_2, r.digest_word_3};
		if (r.action != ACT_NONE && r.reg_idx >= REGS) begin
			o.status = ST_BAD_INDEX;
		end else if (r.action == ACT_EXTEND || r.action == ACT_READ) begin
			if (r.alg_sel != ALG_SHORT && r.alg_sel != ALG_LONG) begin
				o.status = ST_BAD_ALG;
			end else if (r.action == ACT_READ) begin
				if (r.alg_sel == ALG_SHORT) begin
					o.value_size = SHORT_SIZE;
					{o.value_word_0, o.value_word_1, o.value_word_2, o.value_word_3} =
						{short_bank[r.reg_idx], 96'h0};
				end else begin
					o.value_size = LONG_SIZE;
					{o.value_word_0, o.value_word_1, o.value_word_2, o.value_word_3} =
						long_bank[r.reg_idx];
				end
			end else if (r.dgst_len > MAX_DIGEST) begin
				o.status = ST_BAD_SIZE;
			end else begin
				msg = '0;
				if (r.alg_sel == ALG_SHORT) begin
					old = 20;
					msg[1023 -: 160] = short_bank[r.reg_idx];
				end else begin
					old = 32;
					msg[1023 -: 256] = long_bank[r.reg_idx];
				end
				for (int i = 0; i < r.dgst_len; i++)
					msg[1023 - 8*(old + i) -: 8] = dig[255 - 8*i -: 8];
				hv = sha256_msg(msg, old + r.dgst_len);
				if (old == 20) short_bank[r.reg_idx] = hv[255 -: 160];
				else long_bank[r.reg_idx] = hv;
			end
		end else if (r.action == ACT_RESET) begin
			if (r.reg_idx < RESET_GUARD && !loc4) begin
				o.status = ST_REFUSED;
			end else begin
				short_bank[r.reg_idx] = '0;
				long_bank[r.reg_idx] = '0;
			end
		end
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got, input logic [63:0] exp_v);
		$display("mismatch %s: got %h expected %h at %0t", what, got, exp_v, $realtime);
		errors++;
	endtask

	task automatic idle_gap();
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// one request transfer; start held high across back-to-back transfers
	task automatic send_req(input req_t r);
		start <= 1'b1;
		req <= r;
		rsp_queue.push_back(predict_pcr_op(r));
		do @(posedge clk); while (busy);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (rsp_queue.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_locality(input logic v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		loc4 = v;
	endtask

	function automatic req_t mk(input logic [1:0] a, input logic [15:0] alg, input logic [4:0] idx,
		input logic [5:0] sz);
		req_t r;
		r.action = a; r.alg_sel = alg; r.reg_idx = idx; r.dgst_len = sz;
		r.digest_word_0 = {$urandom, $urandom}; r.digest_word_1 = {$urandom, $urandom};
		r.digest_word_2 = {$urandom, $urandom}; r.digest_word_3 = {$urandom, $urandom};
		return r;
	endfunction

	// response checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (rsp_queue.size() == 0) begin
				report_mismatch("unexpected response", 64'(rsp.status), 64'h0);
			end else begin
				rsp_t e;
				e = rsp_queue.pop_front();
				if (rsp.status !== e.status) report_mismatch("status", 64'(rsp.status), 64'(e.status));
				if (rsp.value_size !== e.value_size)
					report_mismatch("value_size", 64'(rsp.value_size), 64'(e.value_size));
				if (rsp.value_word_0 !== e.value_word_0)
					report_mismatch("value_word_0", rsp.value_word_0, e.value_word_0);
				if (rsp.value_word_1 !== e.value_word_1)
					report_mismatch("value_word_1", rsp.value_word_1, e.value_word_1);
				if (rsp.value_word_2 !== e.value_word_2)
					report_mismatch("value_word_2", rsp.value_word_2, e.value_word_2);
				if (rsp.value_word_3 !== e.value_word_3)
					report_mismatch("value_word_3", rsp.value_word_3, e.value_word_3);
			end
		end
	end

	task automatic test_directed();
		req_t r;
		send_req(mk(ACT_READ, ALG_SHORT, 5'd0, 6'd0));
		send_req(mk(ACT_EXTEND, ALG_SHORT, 5'd0, 6'd0));
		send_req(mk(ACT_EXTEND, ALG_SHORT, 5'd0, 6'd32));
		send_req(mk(ACT_EXTEND, ALG_SHORT, 5'd0, 6'd35));
		send_req(mk(ACT_EXTEND, ALG_SHORT, 5'd0, 6'd36));
		send_req(mk(ACT_READ, ALG_SHORT, 5'd0, 6'd63));
		send_req(mk(ACT_EXTEND, ALG_LONG, 5'd23, 6'd23));
		send_req(mk(ACT_EXTEND, ALG_LONG, 5'd23, 6'd24));
		send_req(mk(ACT_EXTEND, ALG_LONG, 5'd23, 6'd33));
		send_req(mk(ACT_EXTEND, ALG_LONG, 5'd24, 6'd63));
		send_req(mk(ACT_READ, ALG_LONG, 5'd23, 6'd0));
		send_req(mk(ACT_READ, 16'hFFFF, 5'd3, 6'd0));
		send_req(mk(ACT_EXTEND, 16'h0000, 5'd3, 6'd40));
		send_req(mk(ACT_READ, 16'h000B, 5'd31, 6'd0));
		send_req(mk(ACT_RESET, 16'hFFFF, 5'd0, 6'd63));
		send_req(mk(ACT_RESET, ALG_SHORT, 5'd16, 6'd0));
		send_req(mk(ACT_RESET, ALG_SHORT, 5'd31, 6'd0));
		send_req(mk(ACT_NONE, 16'hFFFF, 5'd31, 6'd63));
		r = mk(ACT_EXTEND, ALG_LONG, 5'd16, 6'd32);
		r.digest_word_0 = '1; r.digest_word_1 = '1; r.digest_word_2 = '1; r.digest_word_3 = '1;
		send_req(r);
		send_req(mk(ACT_READ, ALG_LONG, 5'd16, 6'd0));
		send_req(mk(ACT_READ, ALG_SHORT, 5'd16, 6'd0));
		drain();
	endtask

	task automatic test_locality_reset();
		write_locality(1'b1);
		send_req(mk(ACT_RESET, 16'h0, 5'd0, 6'd0));
		send_req(mk(ACT_READ, ALG_SHORT, 5'd0, 6'd0));
		send_req(mk(ACT_RESET, 16'h0, 5'd15, 6'd0));
		drain();
	endtask

	function automatic req_t random_req();
		req_t r;
		int p;
		logic [1:0] a;
		logic [15:0] alg;
		logic [4:0] idx;
		logic [5:0] sz;
		p = $urandom_range(0, 99);
		a = (p < 45) ? ACT_EXTEND : (p < 75) ? ACT_READ : (p < 92) ? ACT_RESET : 2'(p);
		p = $urandom_range(0, 9);
		alg = (p < 4) ? ALG_SHORT : (p < 8) ? ALG_LONG : 16'($urandom);
		idx = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31)) : 5'($urandom_range(0, 23));
		sz = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 32));
		r = mk(a, alg, idx, sz);
		return r;
	endfunction

	task automatic test_random(input int n);
		for (int i = 0; i < n; i++) begin
			idle_gap();
			send_req(random_req());
		end
		drain();
	endtask

	initial begin
		for (int i = 0; i < REGS; i++) begin
			short_bank[i] = '0;
			long_bank[i] = '0;
		end
		loc4 = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_locality_reset();
		write_locality(1'b0);
		test_random(450);
		write_locality(1'b1);
		test_random(450);
		write_locality(1'b0);
		idle_on = 1'b0;
		test_random(430);
		if (errors == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("tb failed");
		$finish;
	end
endmodule

[pcr_bank_extend_engine_unit.f]
src/pbe_pkg.sv
src/pbe_datapath.sv
src/pbe_ctrl.sv
src/pcr_bank_extend_engine_unit.sv
src/pbe_checker.sv
test/tb.sv
